FILE: src/svl_pkg.sv
// Shared types and constants for the sortable value list store.
package svl_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned DepthDefault = 16;

  // Action codes carried by an input transfer.
  localparam logic [1:0] ActPush   = 2'd0;
  localparam logic [1:0] ActDelete = 2'd1;
  localparam logic [1:0] ActSort   = 2'd2;
  localparam logic [1:0] ActRead   = 2'd3;

  // Status codes carried by a result transfer.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // Operation applied to every cell of the chain together.
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_PUSH    = 3'd1,
    OP_ROTATE  = 3'd2,
    OP_PRUNE   = 3'd3,
    OP_SORT    = 3'd4,
    OP_COMPACT = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_READ = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

endpackage

FILE: src/svl_cell.sv
// One list cell: an entry, its valid bit and the neighbor exchange logic.
module svl_cell #(
  parameter bit LEFT_EDGE  = 1'b0,
  parameter bit RIGHT_EDGE = 1'b0,
  parameter bit ODD        = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  svl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [svl_pkg::DataW-1:0] key_i,
  input  logic [svl_pkg::DataW-1:0] left_data_i,
  input  logic                      left_valid_i,
  input  logic [svl_pkg::DataW-1:0] right_data_i,
  input  logic                      right_valid_i,
  output logic [svl_pkg::DataW-1:0] data_o,
  output logic                      valid_o
);

  logic [svl_pkg::DataW-1:0] data_q, data_d;
  logic                      valid_q, valid_d;
  logic                      pair_right, pair_left;
  logic [svl_pkg::DataW-1:0] l_data, r_data;
  logic                      l_valid, r_valid;
  logic                      do_swap;

  // In a given phase this cell is the left or the right member of a pair, or unpaired at a chain edge.
  assign pair_right = !RIGHT_EDGE && (ODD == ctrl_i.phase);
  assign pair_left  = !LEFT_EDGE  && (ODD != ctrl_i.phase);

  always_comb begin
    l_data  = pair_right ? data_q       : left_data_i;
    l_valid = pair_right ? valid_q      : left_valid_i;
    r_data  = pair_right ? right_data_i : data_q;
    r_valid = pair_right ? right_valid_i : valid_q;
    if (ctrl_i.op == svl_pkg::OP_SORT) begin
      do_swap = l_valid && r_valid && ($signed(l_data) > $signed(r_data));
    end else begin
      do_swap = !l_valid && r_valid;
    end
    do_swap = do_swap && (pair_right || pair_left);
  end

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      svl_pkg::OP_HOLD: begin
      end
      svl_pkg::OP_PUSH: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      svl_pkg::OP_ROTATE: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      svl_pkg::OP_PRUNE: begin
        valid_d = valid_q && (data_q != key_i);
      end
      svl_pkg::OP_SORT, svl_pkg::OP_COMPACT: begin
        if (do_swap) begin
          data_d  = pair_right ? right_data_i  : left_data_i;
          valid_d = pair_right ? right_valid_i : left_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

FILE: src/sortable_value_list_store.sv
// Top level of the sortable value list store: a chain of list cells and its sequencer.
//
//  channel | direction | signals                                  | transfer when
//  --------+-----------+------------------------------------------+-----------------------
//  in      | sink      | in_valid_i, in_ready_o, action_i, value_i | in_valid_i & in_ready_o
//  out     | source    | out_valid_o, out_ready_i, value_res_o,    | out_valid_o & out_ready_i
//          |           | status_o, last_o                          |
//
// A push presents its status through the response state, full if the list was full.
// Sort and delete run DEPTH odd-even exchange phases across the cell chain before
// the status appears; delete first clears the matching cells in the accepting cycle
// and then compacts the survivors forward, or reports empty on an empty list.
// A read-out rotates the whole chain once, emitting cell zero while it holds a
// valid entry; each entry waits in the output register when the sink stalls, and
// the rotation holds meanwhile. Reset clears every valid bit, which empties the
// list, and returns the sequencer to idle. A new item is accepted whenever the
// sequencer is idle, even while the last result still waits in the output register.
module sortable_value_list_store #(
  parameter int unsigned DEPTH = svl_pkg::DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [svl_pkg::DataW-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [svl_pkg::DataW-1:0] value_res_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  localparam int unsigned CntW = $clog2(DEPTH);
  localparam logic [CntW-1:0] CntLast = CntW'(DEPTH - 1);

  // Cell chain contents as seen by the sequencer.
  logic [svl_pkg::DataW-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]          cell_valid;
  svl_pkg::cell_ctrl_t       ctrl;

  svl_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sort_mode_q, sort_mode_d;
  logic [1:0]      status_q, status_d;

  logic                      out_valid_q, out_valid_d;
  logic [svl_pkg::DataW-1:0] out_value_q, out_value_d;
  logic [1:0]                out_status_q, out_status_d;
  logic                      out_last_q, out_last_d;

  logic list_full, list_empty, out_free;

  // Valid bits always form a prefix, so the ends of the chain tell full and empty.
  assign list_full  = cell_valid[DEPTH-1];
  assign list_empty = !cell_valid[0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == svl_pkg::ST_IDLE);

  // Cell zero is fed by the pushed value from the left, and the last cell is
  // fed by cell zero from the right so that a read-out rotates the list intact.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [svl_pkg::DataW-1:0] left_data, right_data;
    logic                      left_valid, right_valid;

    if (g == 0) begin : g_first
      assign left_data  = value_i;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_data  = cell_data[g-1];
      assign left_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign right_data  = cell_data[0];
      assign right_valid = cell_valid[0];
    end else begin : g_mid_right
      assign right_data  = cell_data[g+1];
      assign right_valid = cell_valid[g+1];
    end

    svl_cell #(
      .LEFT_EDGE  (g == 0),
      .RIGHT_EDGE (g == DEPTH - 1),
      .ODD        (g % 2 == 1)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (value_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sort_mode_d  = sort_mode_q;
    status_d     = status_q;
    ctrl.op      = svl_pkg::OP_HOLD;
    ctrl.phase   = cnt_q[0];
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    case (state_q)
      svl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          case (action_i)
            svl_pkg::ActPush: begin
              if (list_full) begin
                status_d = svl_pkg::StFull;
              end else begin
                status_d = svl_pkg::StOk;
                ctrl.op  = svl_pkg::OP_PUSH;
              end
              state_d = svl_pkg::ST_RESP;
            end
            svl_pkg::ActDelete: begin
              if (list_empty) begin
                status_d = svl_pkg::StEmpty;
                state_d  = svl_pkg::ST_RESP;
              end else begin
                // Matching cells drop their valid bit now; the run closes the gaps.
                ctrl.op     = svl_pkg::OP_PRUNE;
                sort_mode_d = 1'b0;
                state_d     = svl_pkg::ST_RUN;
              end
            end
            svl_pkg::ActSort: begin
              sort_mode_d = 1'b1;
              state_d     = svl_pkg::ST_RUN;
            end
            svl_pkg::ActRead: begin
              if (list_empty) begin
                status_d = svl_pkg::StEmpty;
                state_d  = svl_pkg::ST_RESP;
              end else begin
                state_d = svl_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      svl_pkg::ST_RUN: begin
        ctrl.op = sort_mode_q ? svl_pkg::OP_SORT : svl_pkg::OP_COMPACT;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          status_d = svl_pkg::StOk;
          state_d  = svl_pkg::ST_RESP;
        end
      end
      svl_pkg::ST_READ: begin
        // Empty cells rotate past freely; a valid entry waits for the output slot.
        if (!cell_valid[0] || out_free) begin
          ctrl.op = svl_pkg::OP_ROTATE;
          cnt_d   = cnt_q + 1'b1;
          if (cell_valid[0]) begin
            out_valid_d  = 1'b1;
            out_value_d  = cell_data[0];
            out_status_d = svl_pkg::StOk;
            out_last_d   = !cell_valid[1] || (cnt_q == CntLast);
          end
          if (cnt_q == CntLast) begin
            state_d = svl_pkg::ST_IDLE;
          end
        end
      end
      svl_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = status_q;
          out_last_d   = 1'b1;
          state_d      = svl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = svl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svl_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sort_mode_q  <= sort_mode_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule
